// ----- rtl/core/csv_field_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSVFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSVFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/csvft_pkg.sv -----
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Types, codes and constants shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package csvft_pkg;

	localparam int UNIT_W         = 16;  // width of the code unit fields
	localparam int CODE_UNIT_BITS = 16;  // default significant code unit bits
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		KIND_CHAR      = 3'd0,
		KIND_END_FIELD = 3'd1,
		KIND_END_ROW   = 3'd2,
		KIND_DONE      = 3'd3,
		KIND_ERROR     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_PLAIN   = 2'd0,
		PH_QUOTED  = 2'd1,
		PH_PENDING = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	typedef enum logic {
		MODE_UNIT = 1'b0,
		MODE_END  = 1'b1
	} mode_t;

	// Classified item: first result kind, and whether a text-done result follows.
	typedef struct packed {
		kind_t kind;
		logic  pair;
	} info_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/csvft_front.sv -----
// ----------------------------------------------------------------------------
// CSV field tokenizer front end
// Accepts code units, tracks quoting state and classifies each item.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csvft_front #(
	parameter int CODE_UNIT_BITS = csvft_pkg::CODE_UNIT_BITS,
	localparam int UW = (CODE_UNIT_BITS < csvft_pkg::UNIT_W) ?
		CODE_UNIT_BITS : csvft_pkg::UNIT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [csvft_pkg::UNIT_W-1:0]      s_tdata,   // [15:0] code_unit
	input  logic                              s_tuser,   // [0] mode
	input  csvft_pkg::q_stat_t                q_stat,
	output logic                              push,
	output csvft_pkg::info_t                  push_info,
	output logic [UW-1:0]                     push_unit
);

	csvft_pkg::phase_t phase_q, phase_d;
	logic after_q, after_d;
	logic fhc_q, fhc_d;
	logic rhf_q, rhf_d;
	logic skip_q, skip_d;

	logic          accept;
	logic          res_valid;
	logic [UW-1:0] c;
	logic          is_quote, is_comma, is_lf, is_cr;

	assign c        = s_tdata[UW-1:0];
	assign is_quote = (c == UW'(csvft_pkg::CH_QUOTE));
	assign is_comma = (c == UW'(csvft_pkg::CH_COMMA));
	assign is_lf    = (c == UW'(csvft_pkg::CH_LF));
	assign is_cr    = (c == UW'(csvft_pkg::CH_CR));

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && res_valid;

	always_comb begin
		logic acq;
		logic do_plain;
		phase_d        = phase_q;
		after_d        = after_q;
		fhc_d          = fhc_q;
		rhf_d          = rhf_q;
		skip_d         = skip_q;
		res_valid      = 1'b0;
		push_info.kind = csvft_pkg::KIND_CHAR;
		push_info.pair = 1'b0;
		push_unit      = '0;
		acq            = after_q;
		do_plain       = 1'b0;
		if (s_tuser == csvft_pkg::MODE_END) begin
			phase_d = csvft_pkg::PH_PLAIN;
			after_d = 1'b0;
			fhc_d   = 1'b0;
			rhf_d   = 1'b0;
			skip_d  = 1'b0;
			case (phase_q)
				csvft_pkg::PH_ERROR: begin
				end
				csvft_pkg::PH_QUOTED: begin
					res_valid      = 1'b1;
					push_info.kind = csvft_pkg::KIND_ERROR;
				end
				default: begin
					res_valid = 1'b1;
					if (fhc_q || rhf_q || after_q || phase_q == csvft_pkg::PH_PENDING) begin
						push_info.kind = csvft_pkg::KIND_END_ROW;
						push_info.pair = 1'b1;
					end else begin
						push_info.kind = csvft_pkg::KIND_DONE;
					end
				end
			endcase
		end else begin
			case (phase_q)
				csvft_pkg::PH_ERROR: begin
				end
				csvft_pkg::PH_QUOTED: begin
					if (is_quote) begin
						phase_d = csvft_pkg::PH_PENDING;
					end else begin
						fhc_d     = 1'b1;
						res_valid = 1'b1;
						push_unit = c;
					end
				end
				csvft_pkg::PH_PENDING: begin
					if (is_quote) begin
						phase_d   = csvft_pkg::PH_QUOTED;
						fhc_d     = 1'b1;
						res_valid = 1'b1;
						push_unit = UW'(csvft_pkg::CH_QUOTE);
					end else begin
						phase_d  = csvft_pkg::PH_PLAIN;
						acq      = 1'b1;
						after_d  = 1'b1;
						do_plain = 1'b1;
					end
				end
				default: begin
					// drop the LF of a CR LF pair
					skip_d   = 1'b0;
					do_plain = !(skip_q && is_lf);
				end
			endcase
			if (do_plain) begin
				if (is_quote && !fhc_q && !acq) begin
					phase_d = csvft_pkg::PH_QUOTED;
				end else if (is_comma || is_lf || is_cr) begin
					fhc_d     = 1'b0;
					after_d   = 1'b0;
					res_valid = 1'b1;
					if (is_comma) begin
						rhf_d          = 1'b1;
						push_info.kind = csvft_pkg::KIND_END_FIELD;
					end else begin
						rhf_d          = 1'b0;
						skip_d         = is_cr;
						push_info.kind = csvft_pkg::KIND_END_ROW;
					end
				end else if (acq) begin
					phase_d        = csvft_pkg::PH_ERROR;
					res_valid      = 1'b1;
					push_info.kind = csvft_pkg::KIND_ERROR;
				end else begin
					fhc_d     = 1'b1;
					res_valid = 1'b1;
					push_unit = c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csvft_pkg::PH_PLAIN;
			after_q <= 1'b0;
			fhc_q   <= 1'b0;
			rhf_q   <= 1'b0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			after_q <= after_d;
			fhc_q   <= fhc_d;
			rhf_q   <= rhf_d;
			skip_q  <= skip_d;
		end
	end

	`CSVFT_ASSERT_NOW(a_skip_plain, skip_q, phase_q == csvft_pkg::PH_PLAIN, "CR pending outside plain phase")
	`CSVFT_ASSERT_NOW(a_after_phase, after_q, phase_q == csvft_pkg::PH_PLAIN || phase_q == csvft_pkg::PH_ERROR, "closed quote flag in quoted phase")
	`CSVFT_ASSERT_NEXT(a_end_clears, accept && s_tuser == csvft_pkg::MODE_END, phase_q == csvft_pkg::PH_PLAIN && !after_q && !fhc_q && !rhf_q && !skip_q, "state not cleared after end of text")

endmodule

// ----- rtl/core/csvft_queue.sv -----
// ----------------------------------------------------------------------------
// CSV field tokenizer queue
// Small register FIFO between the classifier and the result emitter.
// ----------------------------------------------------------------------------
module csvft_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = csvft_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   head_data,
	output csvft_pkg::q_stat_t q_stat
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/csvft_back.sv -----
// ----------------------------------------------------------------------------
// CSV field tokenizer back end
// Expands queued items into result items and holds them in the output register.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csvft_back #(
	parameter int CODE_UNIT_BITS = csvft_pkg::CODE_UNIT_BITS,
	localparam int UW = (CODE_UNIT_BITS < csvft_pkg::UNIT_W) ?
		CODE_UNIT_BITS : csvft_pkg::UNIT_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csvft_pkg::q_stat_t           q_stat,
	input  csvft_pkg::info_t             head_info,
	input  logic [UW-1:0]                head_unit,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csvft_pkg::UNIT_W-1:0] m_tdata,   // [15:0] code_unit_res
	output logic [2:0]                   m_tuser,   // [2:0] kind
	output logic                         m_tlast    // last_of_run
);

	logic                         m_tvalid_q;
	logic [csvft_pkg::UNIT_W-1:0] m_tdata_q;
	csvft_pkg::kind_t             m_kind_q;
	logic                         m_tlast_q;
	logic                         second_q;
	logic                         load;
	csvft_pkg::kind_t             kind_sel;
	logic                         last_sel;

	assign load = !m_tvalid_q || m_tready;
	assign pop  = load && !q_stat.empty && (!head_info.pair || second_q);

	always_comb begin
		if (second_q) begin
			kind_sel = csvft_pkg::KIND_DONE;
			last_sel = 1'b1;
		end else if (head_info.pair) begin
			kind_sel = csvft_pkg::KIND_END_ROW;
			last_sel = 1'b0;
		end else begin
			kind_sel = head_info.kind;
			last_sel = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			second_q   <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= !q_stat.empty;
			if (!q_stat.empty && head_info.pair) begin
				second_q <= !second_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			m_kind_q  <= kind_sel;
			m_tlast_q <= last_sel;
			m_tdata_q <= (kind_sel == csvft_pkg::KIND_CHAR) ?
				csvft_pkg::UNIT_W'(head_unit) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_tlast_q;

	`CSVFT_ASSERT_NOW(a_second_has_head, second_q, !q_stat.empty && head_info.pair, "second result without its queued item")
	`CSVFT_ASSERT_NEXT(a_second_is_done, second_q && load, m_tvalid_q && m_kind_q == csvft_pkg::KIND_DONE && m_tlast_q, "second result is not a closing text done")
	`CSVFT_ASSERT_NOW(a_done_is_last, m_tvalid_q && m_kind_q == csvft_pkg::KIND_DONE, m_tlast_q, "text done not marked last")

endmodule

// ----- rtl/core/csv_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a code unit stream into field characters and field and row marks.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle on the slave side while the queue has room
// (tuser high marks end of text) and returns result items on the master
// side, one per cycle while m_tready is high. A classifier tracks quoting
// and feeds a four-entry queue; an emitter drains it into a registered
// output. Most items give zero or one result and sustain one item per cycle;
// an end of text that closes a partial row gives two results from one item.
// Items pass through the queue and then the output register, the only stage
// after it, so input flows while a result waits, until the queue fills.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
	parameter int CODE_UNIT_BITS = csvft_pkg::CODE_UNIT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [csvft_pkg::UNIT_W-1:0] s_tdata,   // [15:0] code_unit
	input  logic                         s_tuser,   // [0] mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csvft_pkg::UNIT_W-1:0] m_tdata,   // [15:0] code_unit_res
	output logic [2:0]                   m_tuser,   // [2:0] kind
	output logic                         m_tlast    // last_of_run
);

	localparam int UW = (CODE_UNIT_BITS < csvft_pkg::UNIT_W) ?
		CODE_UNIT_BITS : csvft_pkg::UNIT_W;
	localparam int INFO_W = $bits(csvft_pkg::info_t);

	csvft_pkg::q_stat_t q_stat;
	logic               push, pop;
	csvft_pkg::info_t   push_info, head_info;
	logic [UW-1:0]      push_unit, head_unit;
	logic [INFO_W+UW-1:0] head_data;

	csvft_front #(
		.CODE_UNIT_BITS(CODE_UNIT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_info (push_info),
		.push_unit (push_unit)
	);

	csvft_queue #(
		.WIDTH(INFO_W + UW),
		.DEPTH(csvft_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_info, push_unit}),
		.pop       (pop),
		.head_data (head_data),
		.q_stat    (q_stat)
	);

	assign head_info = csvft_pkg::info_t'(head_data[INFO_W+UW-1:UW]);
	assign head_unit = head_data[UW-1:0];

	csvft_back #(
		.CODE_UNIT_BITS(CODE_UNIT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_info (head_info),
		.head_unit (head_unit),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
